### src/erm_pkg.sv
// shared types, constants and arithmetic helpers for the euler to rotation matrix block
`default_nettype none
package erm_pkg;

   localparam int unsigned CORDIC_STAGES_DEF = 16;
   localparam int unsigned ANG_W = 32;
   localparam int unsigned EPS_W = 17;
   localparam int unsigned Q14_W = 16;
   localparam int unsigned CW = 34;
   localparam int unsigned LANES = 3;
   localparam int unsigned WRAP_STAGES = 6;
   localparam int unsigned MATRIX_STAGES = 3;

   localparam int unsigned U_W = 33;
   localparam int unsigned Q_W = 15;
   localparam int unsigned R_W = 20;
   localparam int unsigned W_W = 22;

   localparam logic [CW-1:0] U_OFFSET = 34'd2148024287;
   localparam logic [Q_W-1:0] RECIP = 15'd20860;
   localparam logic [CW-1:0] TWO_PI_U = 34'd411775;
   localparam logic [R_W-1:0] TWO_PI_R = 20'd411775;

   localparam logic signed [W_W-1:0] PI_Q16 = 22'sd205887;
   localparam logic signed [W_W-1:0] TWO_PI_Q16 = 22'sd411775;

   localparam logic signed [CW-1:0] PI_Q30 = 34'sd3373259426;
   localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;

   localparam logic signed [2*CW-1:0] RND30 = 68'sd536870912;
   localparam logic signed [CW:0] RND16 = 35'sd32768;
   localparam logic signed [CW:0] ONE_Q14 = 35'sd16384;

   typedef logic signed [CW-1:0] cval_type;

   typedef struct packed {
      logic signed [ANG_W-1:0] yaw_angle;
      logic signed [ANG_W-1:0] pitch_angle;
      logic signed [ANG_W-1:0] roll_angle;
   } req_type;

   typedef struct packed {
      logic signed [Q14_W-1:0] m00;
      logic signed [Q14_W-1:0] m01;
      logic signed [Q14_W-1:0] m02;
      logic signed [Q14_W-1:0] m10;
      logic signed [Q14_W-1:0] m11;
      logic signed [Q14_W-1:0] m12;
      logic signed [Q14_W-1:0] m20;
      logic signed [Q14_W-1:0] m21;
      logic signed [Q14_W-1:0] m22;
   } rsp_type;

   function automatic cval_type atan_value(input int idx);
      cval_type v;
      case (idx)
         0: v = 34'sd843314857;
         1: v = 34'sd497837829;
         2: v = 34'sd263043837;
         3: v = 34'sd133525159;
         4: v = 34'sd67021687;
         5: v = 34'sd33543516;
         6: v = 34'sd16775851;
         7: v = 34'sd8388437;
         8: v = 34'sd4194283;
         9: v = 34'sd2097149;
         10: v = 34'sd1048576;
         11: v = 34'sd524288;
         12: v = 34'sd262144;
         13: v = 34'sd131072;
         14: v = 34'sd65536;
         15: v = 34'sd32768;
         16: v = 34'sd16384;
         17: v = 34'sd8192;
         18: v = 34'sd4096;
         19: v = 34'sd2048;
         20: v = 34'sd1024;
         21: v = 34'sd512;
         22: v = 34'sd256;
         23: v = 34'sd128;
         default: v = '0;
      endcase
      return v;
   endfunction

   // q2.30 product rounded half up
   function automatic cval_type mul30(input cval_type a, input cval_type b);
      logic signed [2*CW-1:0] p;
      p = a * b + RND30;
      return p[CW+29:30];
   endfunction

   // q2.30 to q1.14, rounded half up and clamped to +/-1.0
   function automatic logic signed [Q14_W-1:0] to_q14(input logic signed [CW:0] v);
      logic signed [CW:0] t;
      t = (v + RND16) >>> 16;
      if (t > ONE_Q14) begin
         t = ONE_Q14;
      end
      if (t < -ONE_Q14) begin
         t = -ONE_Q14;
      end
      return t[Q14_W-1:0];
   endfunction

endpackage
`default_nettype wire

### src/erm_wrap.sv
// angle reduction pipeline: modulo 2*pi, edge band, quadrant fold, scale to q2.30
`default_nettype none
module erm_wrap (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            in_valid,
   input  wire erm_pkg::req_type                in_beat,
   input  wire logic [erm_pkg::EPS_W-1:0]       eps,
   output logic                                 out_valid,
   output erm_pkg::cval_type                    z_out [erm_pkg::LANES],
   output logic                                 neg_out [erm_pkg::LANES]
);

   logic signed [erm_pkg::ANG_W-1:0] ang [erm_pkg::LANES];
   logic [erm_pkg::WRAP_STAGES-1:0] valid_ff;

   logic [erm_pkg::U_W-1:0] u1_ff [erm_pkg::LANES];
   logic [erm_pkg::U_W-1:0] u2_ff [erm_pkg::LANES];
   logic [erm_pkg::Q_W-1:0] q2_ff [erm_pkg::LANES];
   logic [erm_pkg::R_W-1:0] r3_ff [erm_pkg::LANES];
   logic signed [erm_pkg::W_W-1:0] m4_ff [erm_pkg::LANES];
   logic signed [erm_pkg::W_W-1:0] w5_ff [erm_pkg::LANES];
   erm_pkg::cval_type z6_ff [erm_pkg::LANES];
   logic neg6_ff [erm_pkg::LANES];

   logic signed [erm_pkg::W_W-1:0] eps_s;

   assign ang[0] = in_beat.yaw_angle;
   assign ang[1] = in_beat.pitch_angle;
   assign ang[2] = in_beat.roll_angle;
   assign eps_s = signed'({{(erm_pkg::W_W-erm_pkg::EPS_W){1'b0}}, eps});

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[erm_pkg::WRAP_STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      logic [erm_pkg::CW-1:0] u_in;
      logic [erm_pkg::U_W+erm_pkg::Q_W-1:0] prod_in;
      logic [erm_pkg::CW-1:0] r_in;
      logic [erm_pkg::R_W-1:0] rc_in;
      logic signed [erm_pkg::W_W-1:0] m_in;
      logic signed [erm_pkg::W_W-1:0] w_in;
      logic signed [erm_pkg::CW+1:0] zw_in;
      erm_pkg::cval_type z_in;
      logic neg_in;
      for (int k = 0; k < erm_pkg::LANES; k++) begin
         // offset by a whole number of turns plus pi so the dividend is positive
         u_in = {{(erm_pkg::CW-erm_pkg::ANG_W){ang[k][erm_pkg::ANG_W-1]}}, ang[k]}
                + erm_pkg::U_OFFSET;
         u1_ff[k] <= u_in[erm_pkg::U_W-1:0];

         prod_in = u1_ff[k] * erm_pkg::RECIP;
         q2_ff[k] <= prod_in[erm_pkg::U_W+erm_pkg::Q_W-1:erm_pkg::U_W];
         u2_ff[k] <= u1_ff[k];

         r_in = erm_pkg::CW'(u2_ff[k]) - erm_pkg::CW'(q2_ff[k]) * erm_pkg::TWO_PI_U;
         r3_ff[k] <= r_in[erm_pkg::R_W-1:0];

         rc_in = (r3_ff[k] >= erm_pkg::TWO_PI_R) ? r3_ff[k] - erm_pkg::TWO_PI_R : r3_ff[k];
         m4_ff[k] <= signed'({{(erm_pkg::W_W-erm_pkg::R_W){1'b0}}, rc_in}) - erm_pkg::PI_Q16;

         // edge band near +/-pi
         m_in = m4_ff[k];
         if (m_in > erm_pkg::PI_Q16 - eps_s) begin
            m_in = m_in - erm_pkg::TWO_PI_Q16;
         end
         if (m_in < eps_s - erm_pkg::PI_Q16) begin
            m_in = m_in + erm_pkg::TWO_PI_Q16;
         end
         w5_ff[k] <= m_in;

         w_in = w5_ff[k];
         if (w_in > erm_pkg::PI_Q16) begin
            w_in = w_in - erm_pkg::TWO_PI_Q16;
         end
         if (w_in < -erm_pkg::PI_Q16) begin
            w_in = w_in + erm_pkg::TWO_PI_Q16;
         end
         zw_in = {{(erm_pkg::CW+2-erm_pkg::W_W){w_in[erm_pkg::W_W-1]}}, w_in} <<< 14;
         z_in = zw_in[erm_pkg::CW-1:0];
         neg_in = 1'b0;
         if (z_in > erm_pkg::HALF_PI_Q30) begin
            z_in = z_in - erm_pkg::PI_Q30;
            neg_in = 1'b1;
         end else if (z_in < -erm_pkg::HALF_PI_Q30) begin
            z_in = z_in + erm_pkg::PI_Q30;
            neg_in = 1'b1;
         end
         z6_ff[k] <= z_in;
         neg6_ff[k] <= neg_in;
      end
   end

   assign out_valid = valid_ff[erm_pkg::WRAP_STAGES-1];
   assign z_out = z6_ff;
   assign neg_out = neg6_ff;

endmodule
`default_nettype wire

### src/erm_cordic.sv
// pipelined rotation cordic, one stage per iteration, three lanes
`default_nettype none
module erm_cordic #(
   parameter int unsigned STAGES = erm_pkg::CORDIC_STAGES_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire erm_pkg::cval_type  z_in [erm_pkg::LANES],
   input  wire logic               neg_in [erm_pkg::LANES],
   output logic                    out_valid,
   output erm_pkg::cval_type       sin_out [erm_pkg::LANES],
   output erm_pkg::cval_type       cos_out [erm_pkg::LANES]
);

   erm_pkg::cval_type x_ff [STAGES][erm_pkg::LANES];
   erm_pkg::cval_type y_ff [STAGES][erm_pkg::LANES];
   erm_pkg::cval_type z_ff [STAGES][erm_pkg::LANES];
   logic neg_ff [STAGES][erm_pkg::LANES];
   erm_pkg::cval_type xs [STAGES][erm_pkg::LANES];
   erm_pkg::cval_type ys [STAGES][erm_pkg::LANES];
   erm_pkg::cval_type zs [STAGES][erm_pkg::LANES];
   logic negs [STAGES][erm_pkg::LANES];
   logic [STAGES:0] valid_ff;
   erm_pkg::cval_type s_ff [erm_pkg::LANES];
   erm_pkg::cval_type c_ff [erm_pkg::LANES];

   always_comb begin
      for (int k = 0; k < erm_pkg::LANES; k++) begin
         xs[0][k] = erm_pkg::GAIN_Q30;
         ys[0][k] = '0;
         zs[0][k] = z_in[k];
         negs[0][k] = neg_in[k];
      end
      for (int g = 1; g < STAGES; g++) begin
         for (int k = 0; k < erm_pkg::LANES; k++) begin
            xs[g][k] = x_ff[g-1][k];
            ys[g][k] = y_ff[g-1][k];
            zs[g][k] = z_ff[g-1][k];
            negs[g][k] = neg_ff[g-1][k];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int g = 0; g < STAGES; g++) begin
         for (int k = 0; k < erm_pkg::LANES; k++) begin
            if (zs[g][k] >= 0) begin
               x_ff[g][k] <= xs[g][k] - (ys[g][k] >>> g);
               y_ff[g][k] <= ys[g][k] + (xs[g][k] >>> g);
               z_ff[g][k] <= zs[g][k] - erm_pkg::atan_value(g);
            end else begin
               x_ff[g][k] <= xs[g][k] + (ys[g][k] >>> g);
               y_ff[g][k] <= ys[g][k] - (xs[g][k] >>> g);
               z_ff[g][k] <= zs[g][k] + erm_pkg::atan_value(g);
            end
            neg_ff[g][k] <= negs[g][k];
         end
      end
      for (int k = 0; k < erm_pkg::LANES; k++) begin
         s_ff[k] <= neg_ff[STAGES-1][k] ? -y_ff[STAGES-1][k] : y_ff[STAGES-1][k];
         c_ff[k] <= neg_ff[STAGES-1][k] ? -x_ff[STAGES-1][k] : x_ff[STAGES-1][k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[STAGES-1:0], in_valid};
      end
   end

   assign out_valid = valid_ff[STAGES];
   assign sin_out = s_ff;
   assign cos_out = c_ff;

endmodule
`default_nettype wire

### src/erm_matrix.sv
// matrix product pipeline: first products, second products, sums with rounding
`default_nettype none
module erm_matrix (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire erm_pkg::cval_type  sin_in [erm_pkg::LANES],
   input  wire erm_pkg::cval_type  cos_in [erm_pkg::LANES],
   output logic                    out_valid,
   output erm_pkg::rsp_type        out_beat
);

   erm_pkg::cval_type sysp_ff, cysp_ff, cycr_ff, sycr_ff, cysr_ff, srcp_ff;
   erm_pkg::cval_type crcp_ff, sycp_ff, cycp_ff, srsy_ff, sp1_ff, sr1_ff, cr1_ff;
   erm_pkg::cval_type a_ff, b_ff, c_ff, d_ff;
   erm_pkg::cval_type cycr2_ff, sycr2_ff, cysr2_ff, srcp2_ff, crcp2_ff;
   erm_pkg::cval_type sycp2_ff, cycp2_ff, srsy2_ff, sp2_ff;
   erm_pkg::rsp_type beat_ff;
   logic [erm_pkg::MATRIX_STAGES-1:0] valid_ff;

   function automatic logic signed [erm_pkg::CW:0] ext(input erm_pkg::cval_type v);
      return {v[erm_pkg::CW-1], v};
   endfunction

   always_ff @(posedge clock) begin
      // lane 0 yaw, lane 1 pitch, lane 2 roll
      sysp_ff <= erm_pkg::mul30(sin_in[0], sin_in[1]);
      cysp_ff <= erm_pkg::mul30(cos_in[0], sin_in[1]);
      cycr_ff <= erm_pkg::mul30(cos_in[0], cos_in[2]);
      sycr_ff <= erm_pkg::mul30(sin_in[0], cos_in[2]);
      cysr_ff <= erm_pkg::mul30(cos_in[0], sin_in[2]);
      srcp_ff <= erm_pkg::mul30(sin_in[2], cos_in[1]);
      crcp_ff <= erm_pkg::mul30(cos_in[2], cos_in[1]);
      sycp_ff <= erm_pkg::mul30(sin_in[0], cos_in[1]);
      cycp_ff <= erm_pkg::mul30(cos_in[0], cos_in[1]);
      srsy_ff <= erm_pkg::mul30(sin_in[2], sin_in[0]);
      sp1_ff <= sin_in[1];
      sr1_ff <= sin_in[2];
      cr1_ff <= cos_in[2];

      a_ff <= erm_pkg::mul30(sysp_ff, sr1_ff);
      b_ff <= erm_pkg::mul30(sysp_ff, cr1_ff);
      c_ff <= erm_pkg::mul30(cysp_ff, sr1_ff);
      d_ff <= erm_pkg::mul30(cysp_ff, cr1_ff);
      cycr2_ff <= cycr_ff;
      sycr2_ff <= sycr_ff;
      cysr2_ff <= cysr_ff;
      srcp2_ff <= srcp_ff;
      crcp2_ff <= crcp_ff;
      sycp2_ff <= sycp_ff;
      cycp2_ff <= cycp_ff;
      srsy2_ff <= srsy_ff;
      sp2_ff <= sp1_ff;

      beat_ff.m00 <= erm_pkg::to_q14(ext(cycr2_ff) + ext(a_ff));
      beat_ff.m01 <= erm_pkg::to_q14(ext(srcp2_ff));
      beat_ff.m02 <= erm_pkg::to_q14(ext(c_ff) - ext(sycr2_ff));
      beat_ff.m10 <= erm_pkg::to_q14(ext(b_ff) - ext(cysr2_ff));
      beat_ff.m11 <= erm_pkg::to_q14(ext(crcp2_ff));
      beat_ff.m12 <= erm_pkg::to_q14(ext(srsy2_ff) + ext(d_ff));
      beat_ff.m20 <= erm_pkg::to_q14(ext(sycp2_ff));
      beat_ff.m21 <= erm_pkg::to_q14(-ext(sp2_ff));
      beat_ff.m22 <= erm_pkg::to_q14(ext(cycp2_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[erm_pkg::MATRIX_STAGES-2:0], in_valid};
      end
   end

   assign out_valid = valid_ff[erm_pkg::MATRIX_STAGES-1];
   assign out_beat = beat_ff;

endmodule
`default_nettype wire

### src/euler_to_rotation_matrix.sv
// top level: euler angles in, 3x3 rotation matrix out
// A new angle triple is taken on every cycle in which start is high and busy is low; busy is
// high only while reset is held. Each triple yields one matrix on rsp_strobe after it has passed
// the angle reduction stages, the cordic stages with the quadrant sign register behind them,
// and the product and rounding stages. The output cannot be held off, so every beat must be
// taken in the cycle it is shown.
// angle_epsilon is written through the csr port, always ready, and should change only while
// no beat is in flight.
`default_nettype none
module euler_to_rotation_matrix #(
   parameter int unsigned CORDIC_STAGES = erm_pkg::CORDIC_STAGES_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire erm_pkg::req_type           req_beat,
   output logic                            rsp_strobe,
   output erm_pkg::rsp_type                rsp_beat,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [erm_pkg::EPS_W-1:0]  csr_data
);

   logic [erm_pkg::EPS_W-1:0] eps_ff;
   logic accept;
   logic wrap_valid;
   erm_pkg::cval_type wrap_z [erm_pkg::LANES];
   logic wrap_neg [erm_pkg::LANES];
   logic cordic_valid;
   erm_pkg::cval_type sin_v [erm_pkg::LANES];
   erm_pkg::cval_type cos_v [erm_pkg::LANES];

   assign busy = reset;
   assign accept = start & ~busy;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         eps_ff <= csr_data;
      end
   end

   erm_wrap u_wrap (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_beat   (req_beat),
      .eps       (eps_ff),
      .out_valid (wrap_valid),
      .z_out     (wrap_z),
      .neg_out   (wrap_neg)
   );

   erm_cordic #(
      .STAGES (CORDIC_STAGES)
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (wrap_valid),
      .z_in      (wrap_z),
      .neg_in    (wrap_neg),
      .out_valid (cordic_valid),
      .sin_out   (sin_v),
      .cos_out   (cos_v)
   );

   erm_matrix u_matrix (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (cordic_valid),
      .sin_in    (sin_v),
      .cos_in    (cos_v),
      .out_valid (rsp_strobe),
      .out_beat  (rsp_beat)
   );

endmodule
`default_nettype wire

### src/erm_checker.sv
// port level checks for the euler to rotation matrix block, bound to the top level
`default_nettype none
module erm_checker #(
   parameter int unsigned CORDIC_STAGES = erm_pkg::CORDIC_STAGES_DEF
) (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire logic              rsp_strobe,
   input wire erm_pkg::rsp_type  rsp_beat
);

   localparam int unsigned LATENCY =
      erm_pkg::WRAP_STAGES + CORDIC_STAGES + 1 + erm_pkg::MATRIX_STAGES;

   // every accepted beat comes out after the fixed latency
   a_beat_out : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_strobe)
      else $error("accepted beat produced no result");

   // no result without a beat accepted the fixed latency earlier
   a_no_extra : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LATENCY))
      else $error("result without matching beat");

   // m21 is -sin(pitch); matrix entries m21, m00 and m22 stay within unit magnitude
   a_range : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_beat.m21 <= 16'sd16384 && rsp_beat.m21 >= -16'sd16384 &&
                      rsp_beat.m00 <= 16'sd16384 && rsp_beat.m00 >= -16'sd16384 &&
                      rsp_beat.m22 <= 16'sd16384 && rsp_beat.m22 >= -16'sd16384))
      else $error("matrix entry out of range");

endmodule

bind euler_to_rotation_matrix erm_checker #(
   .CORDIC_STAGES (CORDIC_STAGES)
) u_erm_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_beat   (rsp_beat)
);
`default_nettype wire

### tb/sv/euler_to_rotation_matrix_checker.sv
// checker for the euler to rotation matrix block: predicts each matrix and compares it
`default_nettype none
module euler_to_rotation_matrix_checker #(
   parameter int unsigned CORDIC_STAGES = erm_pkg::CORDIC_STAGES_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic                       busy,
   input  wire erm_pkg::req_type           req_beat,
   input  wire logic                       rsp_strobe,
   input  wire erm_pkg::rsp_type           rsp_beat,
   input  wire logic                       csr_valid,
   input  wire logic                       csr_ready,
   input  wire logic [erm_pkg::EPS_W-1:0]  csr_data,
   output int                              fail_count,
   output int                              pending_count,
   output int                              matrix_count
);
   import erm_pkg::*;

   localparam longint HALF_TURN = 205887;
   localparam longint FULL_TURN = 411775;
   localparam longint HALF_TURN_Q30 = 64'sd3373259426;
   localparam longint QUARTER_TURN_Q30 = 1686629713;
   localparam longint CORDIC_GAIN = 652032874;
   localparam longint ARCTAN [24] = '{
      843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
      16775851, 8388437, 4194283, 2097149, 1048576, 524288,
      262144, 131072, 65536, 32768, 16384, 8192,
      4096, 2048, 1024, 512, 256, 128};

   longint edge_band;
   rsp_type matrix_queue[$];

   function automatic longint fold_angle(input longint a, input longint band);
      longint m;
      m = (a + HALF_TURN) % FULL_TURN;
      if (m < 0) begin
         m += FULL_TURN;
      end
      m -= HALF_TURN;
      if (m > HALF_TURN - band) begin
         m -= FULL_TURN;
      end
      if (m < -HALF_TURN + band) begin
         m += FULL_TURN;
      end
      if (m > HALF_TURN) begin
         m -= FULL_TURN;
      end
      if (m < -HALF_TURN) begin
         m += FULL_TURN;
      end
      return m;
   endfunction

   function automatic void sine_cosine(input longint a, input longint band,
                                       output longint s, output longint c);
      longint x, y, z, dx, dy;
      bit flip;
      x = CORDIC_GAIN;
      y = 0;
      flip = 0;
      z = fold_angle(a, band) * 16384;
      if (z > QUARTER_TURN_Q30) begin
         z -= HALF_TURN_Q30;
         flip = 1;
      end else if (z < -QUARTER_TURN_Q30) begin
         z += HALF_TURN_Q30;
         flip = 1;
      end
      for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx;
            y += dy;
            z -= ARCTAN[i];
         end else begin
            x += dx;
            y -= dy;
            z += ARCTAN[i];
         end
      end
      s = flip ? -y : y;
      c = flip ? -x : x;
   endfunction

   function automatic longint prod(input longint a, input longint b);
      return (a * b + 64'sd536870912) >>> 30;
   endfunction

   function automatic logic signed [15:0] entry(input longint v);
      longint r;
      r = (v + 32768) >>> 16;
      if (r > 16384) begin
         r = 16384;
      end
      if (r < -16384) begin
         r = -16384;
      end
      return r[15:0];
   endfunction

   function automatic rsp_type predict_matrix(input req_type a, input longint band);
      longint sy, cy, sp, cp, sr, cr, sysp, cysp;
      rsp_type m;
      sine_cosine(longint'(a.yaw_angle), band, sy, cy);
      sine_cosine(longint'(a.pitch_angle), band, sp, cp);
      sine_cosine(longint'(a.roll_angle), band, sr, cr);
      sysp = prod(sy, sp);
      cysp = prod(cy, sp);
      m.m00 = entry(prod(cy, cr) + prod(sysp, sr));
      m.m01 = entry(prod(sr, cp));
      m.m02 = entry(-prod(sy, cr) + prod(cysp, sr));
      m.m10 = entry(-prod(cy, sr) + prod(sysp, cr));
      m.m11 = entry(prod(cr, cp));
      m.m12 = entry(prod(sr, sy) + prod(cysp, cr));
      m.m20 = entry(prod(sy, cp));
      m.m21 = entry(-sp);
      m.m22 = entry(prod(cy, cp));
      return m;
   endfunction

   task automatic compare_entry(input string label, input logic signed [15:0] want,
                                input logic signed [15:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, label, want, got);
         fail_count++;
      end
   endtask

   initial begin
      fail_count = 0;
      matrix_count = 0;
      edge_band = 0;
   end

   assign pending_count = matrix_queue.size();

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         edge_band = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            edge_band = longint'(csr_data);
         end
         if (start && !busy) begin
            matrix_queue.push_back(predict_matrix(req_beat, edge_band));
         end
         if (rsp_strobe) begin
            matrix_count++;
            if (matrix_queue.size() == 0) begin
               $display("%0t: unexpected matrix beat, expected none actual %h",
                        $time, rsp_beat);
               fail_count++;
            end else begin
               want = matrix_queue.pop_front();
               compare_entry("m00", want.m00, rsp_beat.m00);
               compare_entry("m01", want.m01, rsp_beat.m01);
               compare_entry("m02", want.m02, rsp_beat.m02);
               compare_entry("m10", want.m10, rsp_beat.m10);
               compare_entry("m11", want.m11, rsp_beat.m11);
               compare_entry("m12", want.m12, rsp_beat.m12);
               compare_entry("m20", want.m20, rsp_beat.m20);
               compare_entry("m21", want.m21, rsp_beat.m21);
               compare_entry("m22", want.m22, rsp_beat.m22);
            end
         end
      end
   end
endmodule
`default_nettype wire

### tb/sv/euler_to_rotation_matrix_test.sv
// testbench top for the euler to rotation matrix block: stimulus, band settings and verdict
`default_nettype none
module euler_to_rotation_matrix_test;
   import erm_pkg::*;

   localparam int LATENCY = CORDIC_STAGES_DEF + 10;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_PER_BAND = 220;
   localparam int HALF_TURN = 205887;
   localparam int FULL_TURN = 411775;
   localparam int QUARTER_TURN = 102944;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   req_type req_beat = '0;
   logic rsp_strobe;
   rsp_type rsp_beat;
   logic csr_valid = 0;
   logic csr_ready;
   logic [EPS_W-1:0] csr_data = '0;
   int fail_count, pending_count, matrix_count;
   int cycle_count = 0;
   int burst_left = 0;
   int angles_sent = 0;

   euler_to_rotation_matrix i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_beat(req_beat),
      .rsp_strobe(rsp_strobe), .rsp_beat(rsp_beat),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data));

   euler_to_rotation_matrix_checker i_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_beat(req_beat),
      .rsp_strobe(rsp_strobe), .rsp_beat(rsp_beat),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .fail_count(fail_count), .pending_count(pending_count),
      .matrix_count(matrix_count));

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic send_angles(input req_type a);
      start <= 1;
      req_beat <= a;
      do @(posedge clock); while (busy);
      angles_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         start <= 0;
         repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : $urandom_range(1, 3))
            @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 8);
      end
   endtask

   task automatic drain;
      start <= 0;
      do @(posedge clock); while (pending_count != 0);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_band(input logic [EPS_W-1:0] band);
      csr_valid <= 1;
      csr_data <= band;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      csr_data <= EPS_W'($urandom());
   endtask

   function automatic logic signed [31:0] pick_angle(input logic [EPS_W-1:0] band);
      int k;
      k = $urandom_range(0, 9);
      case (k)
         0, 1: return $urandom();
         2: return $signed($urandom_range(0, 2 * FULL_TURN)) - FULL_TURN;
         3: return HALF_TURN - int'(band) + $signed($urandom_range(0, 6)) - 3;
         4: return -HALF_TURN + int'(band) + $signed($urandom_range(0, 6)) - 3;
         5: return ($urandom_range(0, 1) ? QUARTER_TURN : -QUARTER_TURN)
                   + $signed($urandom_range(0, 4)) - 2;
         6: return $signed($urandom_range(0, 40)) * FULL_TURN - 20 * FULL_TURN
                   + ($urandom_range(0, 1) ? HALF_TURN : -HALF_TURN);
         default: return $signed($urandom_range(0, 8 * HALF_TURN)) - 4 * HALF_TURN;
      endcase
   endfunction

   task automatic directed_set;
      logic signed [31:0] edges [14];
      req_type a;
      edges = '{0, 1, -1, 32'sh7fffffff, 32'sh80000000, HALF_TURN, -HALF_TURN,
                HALF_TURN + 1, -HALF_TURN - 1, QUARTER_TURN, -QUARTER_TURN,
                QUARTER_TURN - 1, FULL_TURN, -FULL_TURN};
      foreach (edges[i]) begin
         a.yaw_angle = edges[i];
         a.pitch_angle = edges[(i + 5) % 14];
         a.roll_angle = edges[(i + 9) % 14];
         send_angles(a);
      end
      a = '{32'hffffffff, 32'hffffffff, 32'hffffffff};
      send_angles(a);
      a = '{32'h55555555, 32'haaaaaaaa, 32'h12345678};
      send_angles(a);
   endtask

   initial begin
      logic [EPS_W-1:0] bands [7];
      req_type a;
      bands = '{17'd0, 17'd65536, 17'd1, 17'd131071, 17'd205, 17'd0, 17'd0};
      bands[5] = EPS_W'($urandom_range(0, 65536));
      bands[6] = EPS_W'($urandom());
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      directed_set();
      foreach (bands[b]) begin
         drain();
         write_band(bands[b]);
         if (b < 4) begin
            directed_set();
         end
         repeat (RANDOM_PER_BAND - (b < 4 ? 16 : 0) - 40) begin
            a.yaw_angle = pick_angle(bands[b]);
            a.pitch_angle = pick_angle(bands[b]);
            a.roll_angle = pick_angle(bands[b]);
            send_angles(a);
         end
         // back to back beats with no gaps
         start <= 1;
         repeat (40) begin
            a.yaw_angle = pick_angle(bands[b]);
            a.pitch_angle = pick_angle(bands[b]);
            a.roll_angle = pick_angle(bands[b]);
            req_beat <= a;
            do @(posedge clock); while (busy);
            angles_sent++;
         end
      end
      drain();
      $display("sent %0d angle triples over %0d edge band settings, checked %0d matrices",
               angles_sent, 8, matrix_count);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
`default_nettype wire

### sim.f
src/erm_pkg.sv
src/erm_wrap.sv
src/erm_cordic.sv
src/erm_matrix.sv
src/euler_to_rotation_matrix.sv
src/erm_checker.sv
tb/sv/euler_to_rotation_matrix_checker.sv
tb/sv/euler_to_rotation_matrix_test.sv
